// ===== hdl/ctxmb_pkg.sv =====
// Package for the CAN transmit mailbox identifier cache.
// Holds the shared widths, constants, result types and header packing function.
// Has no dependencies.
package ctxmb_pkg;

    localparam int MAILBOXES = 3;
    localparam int ID_W      = 29;
    localparam int PAYLOAD_W = 64;
    localparam int PEND_W    = 3;
    localparam int MBOX_W    = 2;
    localparam int DLC_W     = 4;

    localparam logic [ID_W-1:0]  EXT_LIMIT = ID_W'(32'h800);
    localparam logic [DLC_W-1:0] DLC_FULL  = DLC_W'(8);

    typedef struct packed {
        logic              sent;
        logic              header_load;
        logic [MBOX_W-1:0] mailbox;
    } pick_t;

    typedef struct packed {
        logic [7:0] id_high_byte;
        logic [7:0] id_low_byte;
        logic [7:0] ext_high_byte;
        logic [7:0] ext_low_byte;
    } hdr_t;

    function automatic hdr_t pack_header(input logic [ID_W-1:0] id);
        hdr_t h;
        logic ext_flag;
        ext_flag        = (id >= EXT_LIMIT);
        h.id_high_byte  = id[10:3];
        h.id_low_byte   = {id[2:0], 1'b0, ext_flag, 1'b0, id[28:27]};
        h.ext_high_byte = id[26:19];
        h.ext_low_byte  = id[18:11];
        return h;
    endfunction

    function automatic logic [MAILBOXES-1:0] first_one(input logic [MAILBOXES-1:0] v);
        return v & (~v + MAILBOXES'(1));
    endfunction

endpackage

// ===== hdl/ctxmb_cache.sv =====
// Identifier cache and mailbox selection for the CAN transmit mailbox block.
// Keeps one cached identifier and one used flag per mailbox.
// Depends on ctxmb_pkg.
module ctxmb_cache (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ctxmb_pkg::ID_W-1:0]     frame_id,
    input  logic [ctxmb_pkg::PEND_W-1:0]   tx_pending,
    input  logic                           commit,
    output ctxmb_pkg::pick_t               pick
);

    localparam int PendWideW = ctxmb_pkg::PEND_W + ctxmb_pkg::MAILBOXES;

    logic [ctxmb_pkg::ID_W-1:0]      cached_id_reg [ctxmb_pkg::MAILBOXES];
    logic [ctxmb_pkg::MAILBOXES-1:0] slot_used_reg;
    logic [ctxmb_pkg::MAILBOXES-1:0] slot_used_next;
    logic [PendWideW-1:0]            pend_wide;
    logic [ctxmb_pkg::MAILBOXES-1:0] hit_vec;
    logic [ctxmb_pkg::MAILBOXES-1:0] idle_vec;
    logic [ctxmb_pkg::MAILBOXES-1:0] sel_vec;
    logic [ctxmb_pkg::MAILBOXES-1:0] wr_vec;

    assign pend_wide = PendWideW'(tx_pending);

    always_comb begin
        for (int i = 0; i < ctxmb_pkg::MAILBOXES; i++) begin
            hit_vec[i]  = slot_used_reg[i] && (cached_id_reg[i] == frame_id);
            idle_vec[i] = !pend_wide[i];
        end
    end

    always_comb begin
        pick    = '0;
        sel_vec = '0;
        if (|hit_vec) begin
            sel_vec   = ctxmb_pkg::first_one(hit_vec);
            pick.sent = 1'b1;
        end else if (!(&slot_used_reg)) begin
            sel_vec          = ctxmb_pkg::first_one(~slot_used_reg);
            pick.sent        = 1'b1;
            pick.header_load = 1'b1;
        end else if (|idle_vec) begin
            sel_vec          = ctxmb_pkg::first_one(idle_vec);
            pick.sent        = 1'b1;
            pick.header_load = 1'b1;
        end
        for (int i = 0; i < ctxmb_pkg::MAILBOXES; i++) begin
            if (sel_vec[i]) begin
                pick.mailbox = pick.mailbox | ctxmb_pkg::MBOX_W'(i);
            end
        end
    end

    assign wr_vec         = (commit && pick.header_load) ? sel_vec : '0;
    assign slot_used_next = slot_used_reg | wr_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_used_reg <= '0;
        end else begin
            slot_used_reg <= slot_used_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ctxmb_pkg::MAILBOXES; i++) begin
            if (wr_vec[i]) begin
                cached_id_reg[i] <= frame_id;
            end
        end
    end

`ifndef SYNTHESIS
    a_wr_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(wr_vec))
        else $error("More than one mailbox written at once.");

    a_busy_all_used: assert property (@(posedge aclk) disable iff (!aresetn)
        !pick.sent |-> (&slot_used_reg))
        else $error("Request refused while a mailbox is still free.");

    a_write_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_vec != '0) |=> ((slot_used_reg & $past(wr_vec)) == $past(wr_vec)))
        else $error("Loaded mailbox not marked as used.");

    a_used_sticky: assert property (@(posedge aclk)
        (aresetn && $past(aresetn))
            |-> ((slot_used_reg & $past(slot_used_reg)) == $past(slot_used_reg)))
        else $error("Used mailbox flag cleared outside reset.");
`endif

endmodule

// ===== hdl/can_tx_mailbox_id_cache.sv =====
// Top level of the CAN transmit mailbox identifier cache.
// A request is held in input registers, then in output registers until m_ready.
// Throughput: one request per cycle while m_ready is high; lookup and update coincide.
// Reset: synchronous, active low; clears both valid flags and marks all mailboxes free.
// Depends on ctxmb_pkg and ctxmb_cache.
module can_tx_mailbox_id_cache (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ctxmb_pkg::ID_W-1:0]        s_frame_id,
    input  logic [ctxmb_pkg::PAYLOAD_W-1:0]   s_payload,
    input  logic [ctxmb_pkg::PEND_W-1:0]      s_tx_pending,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ctxmb_pkg::MBOX_W-1:0]      m_mailbox,
    output logic                              m_sent,
    output logic                              m_header_load,
    output logic [7:0]                        m_id_high_byte,
    output logic [7:0]                        m_id_low_byte,
    output logic [7:0]                        m_ext_high_byte,
    output logic [7:0]                        m_ext_low_byte,
    output logic [ctxmb_pkg::DLC_W-1:0]       m_length_code,
    output logic [ctxmb_pkg::PAYLOAD_W-1:0]   m_payload_out
);

    logic                              in_valid_reg;
    logic [ctxmb_pkg::ID_W-1:0]        frame_id_reg;
    logic [ctxmb_pkg::PAYLOAD_W-1:0]   payload_reg;
    logic [ctxmb_pkg::PEND_W-1:0]      pending_reg;
    logic                              out_valid_reg;
    ctxmb_pkg::pick_t                  pick_reg;
    ctxmb_pkg::hdr_t                   hdr_reg;
    logic [ctxmb_pkg::PAYLOAD_W-1:0]   payload_out_reg;
    ctxmb_pkg::pick_t                  pick;
    logic                              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ctxmb_cache u_cache (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_id   (frame_id_reg),
        .tx_pending (pending_reg),
        .commit     (advance),
        .pick       (pick)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            frame_id_reg <= s_frame_id;
            payload_reg  <= s_payload;
            pending_reg  <= s_tx_pending;
        end
        if (advance) begin
            pick_reg        <= pick;
            hdr_reg         <= ctxmb_pkg::pack_header(frame_id_reg);
            payload_out_reg <= payload_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_mailbox       = pick_reg.mailbox;
    assign m_sent          = pick_reg.sent;
    assign m_header_load   = pick_reg.header_load;
    assign m_id_high_byte  = hdr_reg.id_high_byte;
    assign m_id_low_byte   = hdr_reg.id_low_byte;
    assign m_ext_high_byte = hdr_reg.ext_high_byte;
    assign m_ext_low_byte  = hdr_reg.ext_low_byte;
    assign m_length_code   = ctxmb_pkg::DLC_FULL;
    assign m_payload_out   = payload_out_reg;

endmodule
